// ----- sv/pws_pkg.sv -----
// package for packet window statistics: sizes, register indexes, queue entry type
// no dependencies
package pws_pkg;
    localparam int SLOTS = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int OUT_CNT_W = 11;
    localparam logic [30:0] RATE_MAX = 31'h7fffffff;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_WINDOW = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;
    localparam logic [1:0] REG_EMPTY_MIN = 2'd3;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef struct packed {
        logic [30:0] now_ms;
    } t_update;

    typedef struct packed {
        logic [30:0] bytes_per_second;
        logic [10:0] window_samples;
        logic [10:0] window_fragments;
        logic [6:0]  fragment_percent;
        logic [15:0] largest_bytes;
        logic [15:0] smallest_bytes;
    } t_result;
endpackage

// ----- sv/pws_front.sv -----
// front part: config registers, record writes into the ring, update queue
// depends on pws_pkg
module pws_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  logic            i_command,
    input  logic [30:0]     i_now_ms,
    input  logic            i_cfg_valid,
    input  logic [1:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data,
    output logic            o_wr_en,
    output logic [pws_pkg::SLOT_W-1:0] o_wr_ptr,
    output logic            o_upd_valid,
    output pws_pkg::t_update o_upd,
    input  logic            i_upd_take,
    input  logic            i_busy,
    output logic [15:0]     o_window_ms,
    output logic [15:0]     o_interval_ms,
    output logic [15:0]     o_empty_min
);
    import pws_pkg::*;

    logic r_enable;
    logic [15:0] r_window, r_interval, r_empty_min;
    logic [SLOT_W-1:0] r_ptr;
    logic [1:0] r_q_cnt;
    logic r_q_rd, r_q_wr;
    t_update r_q [2];
    logic acc, push_upd;

    // records go straight to the ring, so no beat is taken while an update waits or runs
    assign o_full = (r_q_cnt != 2'd0) || i_busy;
    assign acc = i_push && !o_full;
    assign push_upd = acc && (i_command == CMD_UPDATE);
    assign o_wr_en = acc && (i_command == CMD_RECORD) && r_enable;
    assign o_wr_ptr = r_ptr + 1'b1;
    assign o_upd_valid = (r_q_cnt != 2'd0);
    assign o_upd = r_q[r_q_rd];
    assign o_window_ms = r_window;
    assign o_interval_ms = r_interval;
    assign o_empty_min = r_empty_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_window <= 16'd1000;
            r_interval <= 16'd100;
            r_empty_min <= 16'd9999;
            r_ptr <= '0;
            r_q_cnt <= '0;
            r_q_rd <= 1'b0;
            r_q_wr <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_ENABLE:    r_enable <= i_cfg_data[0];
                    REG_WINDOW:    r_window <= i_cfg_data;
                    REG_INTERVAL:  r_interval <= i_cfg_data;
                    REG_EMPTY_MIN: r_empty_min <= i_cfg_data;
                endcase
            end
            if (o_wr_en) r_ptr <= o_wr_ptr;
            if (push_upd) r_q_wr <= !r_q_wr;
            if (i_upd_take) r_q_rd <= !r_q_rd;
            r_q_cnt <= r_q_cnt + {1'b0, push_upd} - {1'b0, i_upd_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_upd) r_q[r_q_wr].now_ms <= i_now_ms;
    end
endmodule

// ----- sv/pws_div.sv -----
// serial restoring divider, one quotient bit per cycle
// depends on pws_pkg
module pws_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    import pws_pkg::*;

    logic r_busy;
    logic [5:0] r_cnt;
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [32:0] sh, df;

    assign sh = {r_rem[31:0], r_q[63]};
    assign df = sh - {1'b0, r_den};
    assign o_quo = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
                r_q <= i_num;
                r_rem <= '0;
                r_den <= i_den;
            end else if (r_busy) begin
                if (!df[32]) begin
                    r_rem <= df;
                    r_q <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= sh;
                    r_q <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ----- sv/pws_back.sv -----
// back part: slot memories, window scan, percent and rate, result queue
// depends on pws_pkg and pws_div
module pws_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  logic [pws_pkg::SLOT_W-1:0] i_wr_ptr,
    input  logic [30:0]     i_now_ms,
    input  logic [15:0]     i_packet_bytes,
    input  logic            i_fragmented,
    input  logic            i_upd_valid,
    input  pws_pkg::t_update i_upd,
    output logic            o_upd_take,
    output logic            o_busy,
    input  logic [15:0]     i_window_ms,
    input  logic [15:0]     i_interval_ms,
    input  logic [15:0]     i_empty_min,
    output logic            o_empty,
    input  logic            i_pop,
    output pws_pkg::t_result o_res
);
    import pws_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_SCAN, S_LAST, S_PCT, S_RATE, S_DIV, S_OUT
    } t_state;

    t_state r_st;
    logic [30:0] m_time [SLOTS];
    logic [15:0] m_bytes [SLOTS];
    logic m_frag [SLOTS];
    logic [30:0] r_rt;
    logic [15:0] r_rb;
    logic r_rf;

    logic [SLOT_W-1:0] r_idx, r_ridx;
    logic [CNT_W-1:0] r_cnt, r_frags;
    logic [15:0] r_min, r_max, r_obytes;
    logic r_ofrag, r_have;
    logic [30:0] r_otime, r_now, r_last, r_held;
    logic [SLOT_W+15:0] r_total;
    logic [CNT_W+6:0] r_pn;
    logic [6:0] r_pct;
    logic [2:0] r_pstep;
    logic r_res_v;
    t_result r_res;
    logic [31:0] r_elapsed;

    logic div_start, div_done;
    logic [63:0] div_quo;
    logic [63:0] num;
    logic in_win;
    logic [31:0] lim;
    logic [CNT_W+6:0] ptry;
    logic [SLOT_W+15:0] tot_adj;
    logic [CNT_W-1:0] cnt_adj, frg_adj, frg_fin;

    assign lim = {1'b0, r_rt} + {16'd0, i_window_ms};
    assign in_win = (r_rt != '0) && !({1'b0, r_now} > lim);
    assign o_empty = !r_res_v;
    assign o_res = r_res;
    assign o_busy = (r_st != S_IDLE);
    assign o_upd_take = (r_st == S_IDLE) && i_upd_valid && !r_res_v;
    assign tot_adj = r_total - (r_have ? {{SLOT_W{1'b0}}, r_obytes} : '0);
    assign cnt_adj = r_cnt - {{(CNT_W-1){1'b0}}, r_have};
    assign frg_adj = r_frags - {{(CNT_W-1){1'b0}}, r_have && r_ofrag};
    assign frg_fin = r_frags + {{(CNT_W-1){1'b0}}, in_win && r_rf};
    assign num = {{(48-SLOT_W){1'b0}}, tot_adj} * 64'd1000;
    assign div_start = (r_st == S_RATE) && !((r_elapsed == 0) || (cnt_adj == 0)
                       || (tot_adj == 0));
    assign ptry = {r_pn[CNT_W+6:0]} - ({7'd0, r_cnt} << r_pstep);

    pws_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(num),
        .i_den(r_elapsed), .o_done(div_done), .o_quo(div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            m_bytes[i_wr_ptr] <= i_packet_bytes;
            m_frag[i_wr_ptr] <= i_fragmented;
        end
        r_rb <= m_bytes[r_ridx];
        r_rf <= m_frag[r_ridx];
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_CLEAR) m_time[r_ridx] <= '0;
        else if (i_wr_en) m_time[i_wr_ptr] <= i_now_ms;
        r_rt <= m_time[r_ridx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR;
            r_ridx <= '0;
            r_res_v <= 1'b0;
            r_last <= '0;
            r_held <= '0;
        end else begin
            if (i_pop && r_res_v) r_res_v <= 1'b0;
            unique case (r_st)
                S_CLEAR: begin
                    r_ridx <= r_ridx + 1'b1;
                    if (r_ridx == SLOT_W'(SLOTS - 1)) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    r_ridx <= '0;
                    if (o_upd_take) begin
                        r_now <= i_upd.now_ms;
                        r_otime <= i_upd.now_ms;
                        r_have <= 1'b0;
                        r_cnt <= '0;
                        r_frags <= '0;
                        r_total <= '0;
                        r_min <= i_empty_min;
                        r_max <= '0;
                        r_ridx <= SLOT_W'(1);
                        r_idx <= '0;
                        r_st <= S_SCAN;
                    end
                end
                S_SCAN, S_LAST: begin
                    if (in_win) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_frags <= r_frags + {{(CNT_W-1){1'b0}}, r_rf};
                        r_total <= r_total + {{SLOT_W{1'b0}}, r_rb};
                        if (r_rb < r_min) r_min <= r_rb;
                        if (r_rb > r_max) r_max <= r_rb;
                        if (r_rt < r_otime) begin
                            r_otime <= r_rt;
                            r_obytes <= r_rb;
                            r_ofrag <= r_rf;
                            r_have <= 1'b1;
                        end
                    end
                    r_idx <= r_idx + 1'b1;
                    r_ridx <= r_ridx + 1'b1;
                    if (r_st == S_LAST) begin
                        // fragments times 100 as 64 + 32 + 4
                        r_pn <= ({7'd0, frg_fin} << 6) + ({7'd0, frg_fin} << 5)
                                + ({7'd0, frg_fin} << 2);
                        r_pct <= '0;
                        r_pstep <= 3'd6;
                        r_st <= S_PCT;
                    end else if (r_idx == SLOT_W'(SLOTS - 2)) begin
                        r_st <= S_LAST;
                    end
                end
                S_PCT: begin
                    if (r_cnt == 0) begin
                        r_held <= '0;
                        r_last <= '0;
                        r_res <= '0;
                        r_res_v <= 1'b1;
                        r_st <= S_IDLE;
                    end else begin
                        if (!ptry[CNT_W+6] && (({7'd0, r_cnt} << r_pstep) <= r_pn)) begin
                            r_pn <= ptry;
                            r_pct[r_pstep] <= 1'b1;
                        end
                        r_pstep <= r_pstep - 1'b1;
                        if (r_pstep == 3'd0) begin
                            r_elapsed <= {1'b0, r_now - r_otime};
                            if ({1'b0, r_last} + {16'd0, i_interval_ms} < {1'b0, r_now})
                                r_st <= S_RATE;
                            else r_st <= S_OUT;
                        end
                    end
                end
                S_RATE: begin
                    r_last <= r_now;
                    r_cnt <= cnt_adj;
                    r_frags <= frg_adj;
                    if (div_start) r_st <= S_DIV;
                    else begin
                        r_held <= '0;
                        r_st <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_held <= (div_quo > {33'd0, RATE_MAX}) ? RATE_MAX : div_quo[30:0];
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_res.bytes_per_second <= r_held;
                    r_res.window_samples <= OUT_CNT_W'(r_cnt);
                    r_res.window_fragments <= OUT_CNT_W'(r_frags);
                    r_res.fragment_percent <= r_pct;
                    r_res.largest_bytes <= r_max;
                    r_res.smallest_bytes <= r_min;
                    r_res_v <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- sv/packet_window_statistics.sv -----
// Packet window statistics, one block per traffic direction. A record beat
// writes the ring when enabled. An update beat scans the 64 slots, one per
// cycle, then, for a nonempty window, finds the percent in seven steps and,
// when the rate is due and elapsed time, samples and bytes are nonzero, runs
// the serial divider. While an update waits or runs, full stays high, so
// records never overtake it. After reset a clearing pass over the 64 slots
// empties the time store with full high. Config writes are always ready.
// depends on pws_pkg, pws_front, pws_back
module packet_window_statistics (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_command,
    input  logic [30:0] i_now_ms,
    input  logic [15:0] i_packet_bytes,
    input  logic        i_fragmented,
    output logic        empty,
    input  logic        pop,
    output logic [30:0] o_bytes_per_second,
    output logic [10:0] o_window_samples,
    output logic [10:0] o_window_fragments,
    output logic [6:0]  o_fragment_percent,
    output logic [15:0] o_largest_bytes,
    output logic [15:0] o_smallest_bytes,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import pws_pkg::*;

    logic wr_en, upd_valid, upd_take, busy;
    logic [SLOT_W-1:0] wr_ptr;
    t_update upd;
    t_result res;
    logic [15:0] window_ms, interval_ms, empty_min;

    assign o_cfg_ready = 1'b1;

    pws_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_command(i_command), .i_now_ms(i_now_ms), .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .o_wr_en(wr_en),
        .o_wr_ptr(wr_ptr), .o_upd_valid(upd_valid), .o_upd(upd),
        .i_upd_take(upd_take), .i_busy(busy), .o_window_ms(window_ms),
        .o_interval_ms(interval_ms), .o_empty_min(empty_min)
    );

    pws_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr_en(wr_en), .i_wr_ptr(wr_ptr),
        .i_now_ms(i_now_ms), .i_packet_bytes(i_packet_bytes),
        .i_fragmented(i_fragmented), .i_upd_valid(upd_valid), .i_upd(upd),
        .o_upd_take(upd_take), .o_busy(busy), .i_window_ms(window_ms),
        .i_interval_ms(interval_ms), .i_empty_min(empty_min), .o_empty(empty),
        .i_pop(pop), .o_res(res)
    );

    assign o_bytes_per_second = res.bytes_per_second;
    assign o_window_samples = res.window_samples;
    assign o_window_fragments = res.window_fragments;
    assign o_fragment_percent = res.fragment_percent;
    assign o_largest_bytes = res.largest_bytes;
    assign o_smallest_bytes = res.smallest_bytes;
endmodule

// ----- sv/pws_checker.sv -----
// port-level checks for packet_window_statistics, bound to the top level
// depends on nothing beyond the top level's ports
module pws_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [30:0] o_bytes_per_second,
    input logic [10:0] o_window_samples,
    input logic [10:0] o_window_fragments,
    input logic [6:0]  o_fragment_percent,
    input logic [15:0] o_largest_bytes,
    input logic [15:0] o_smallest_bytes
);
    a_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_fragment_percent <= 7'd100) else $error("percent too big");
    a_frag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_window_fragments <= o_window_samples)
        else $error("fragments exceed samples");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_bytes_per_second)))
        else $error("result dropped");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_largest_bytes == 16'd0 && o_window_samples == 11'd0
         && o_smallest_bytes == 16'd0) |-> o_bytes_per_second == 31'd0)
        else $error("rate without samples");
endmodule

bind packet_window_statistics pws_checker u_pws_checker (.*);

// ----- test/tb_packet_window_statistics.sv -----
// testbench for packet_window_statistics: random and directed record/update beats,
// self-checking against an in-bench predictor of the sample ring
// depends on pws_pkg and packet_window_statistics
`timescale 1ns / 100ps

module tb_packet_window_statistics;
    import pws_pkg::*;

    class window_scoreboard;
        logic        enable;
        logic [15:0] window_len;
        logic [15:0] rate_gap;
        logic [15:0] min_start;
        logic [30:0] ring_time [SLOTS];
        logic [15:0] ring_bytes [SLOTS];
        logic        ring_frag [SLOTS];
        logic [SLOT_W-1:0] ring_ptr;
        logic [30:0] rate_stamp;
        logic [30:0] rate_held;
        t_result     pending [$];
        int          errors;
        int          checked;

        function void clear();
            enable = 1'b0;
            window_len = 16'd1000;
            rate_gap = 16'd100;
            min_start = 16'd9999;
            foreach (ring_time[i]) begin
                ring_time[i] = '0;
                ring_bytes[i] = '0;
                ring_frag[i] = 1'b0;
            end
            ring_ptr = '0;
            rate_stamp = '0;
            rate_held = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                REG_ENABLE: enable = data[0];
                REG_WINDOW: window_len = data;
                REG_INTERVAL: rate_gap = data;
                REG_EMPTY_MIN: min_start = data;
                default: ;
            endcase
        endfunction

        function void note_input(logic cmd, logic [30:0] now, logic [15:0] nbytes, logic frag);
            int unsigned cnt, frg, pct, oldest_idx;
            logic [15:0] minb, maxb;
            logic [30:0] oldest_t;
            logic        has_oldest;
            longint unsigned total, rate;
            longint unsigned elapsed;
            t_result     r;
            if (cmd == CMD_RECORD) begin
                if (enable) begin
                    ring_ptr = ring_ptr + 1'b1;
                    ring_time[ring_ptr] = now;
                    ring_bytes[ring_ptr] = nbytes;
                    ring_frag[ring_ptr] = frag;
                end
                return;
            end
            cnt = 0; frg = 0; minb = min_start; maxb = '0; total = 0;
            oldest_t = now; has_oldest = 1'b0; oldest_idx = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (ring_time[i] == 0 ||
                    longint'(now) > longint'(ring_time[i]) + longint'(window_len))
                    continue;
                cnt++;
                if (ring_frag[i]) frg++;
                if (ring_time[i] < oldest_t) begin
                    oldest_t = ring_time[i];
                    oldest_idx = i;
                    has_oldest = 1'b1;
                end
                total += ring_bytes[i];
                if (ring_bytes[i] < minb) minb = ring_bytes[i];
                if (ring_bytes[i] > maxb) maxb = ring_bytes[i];
            end
            r = '0;
            if (cnt == 0) begin
                rate_held = '0;
                rate_stamp = '0;
                pending.push_back(r);
                return;
            end
            pct = frg * 100 / cnt;
            if (longint'(rate_stamp) + longint'(rate_gap) < longint'(now)) begin
                elapsed = now - oldest_t;
                if (has_oldest) begin
                    total -= ring_bytes[oldest_idx];
                    cnt--;
                    if (ring_frag[oldest_idx]) frg--;
                end
                if (elapsed < 1 || cnt == 0 || total == 0) begin
                    rate_held = '0;
                end else begin
                    rate = total * 1000 / elapsed;
                    rate_held = (rate > RATE_MAX) ? RATE_MAX : rate[30:0];
                end
                rate_stamp = now;
            end
            r.bytes_per_second = rate_held;
            r.window_samples = cnt[10:0];
            r.window_fragments = frg[10:0];
            r.fragment_percent = pct[6:0];
            r.largest_bytes = maxb;
            r.smallest_bytes = minb;
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got.bytes_per_second !== exp.bytes_per_second) begin
                $error("bytes_per_second exp %0d got %0d", exp.bytes_per_second,
                       got.bytes_per_second);
                errors++;
            end
            if (got.window_samples !== exp.window_samples) begin
                $error("window_samples exp %0d got %0d", exp.window_samples,
                       got.window_samples);
                errors++;
            end
            if (got.window_fragments !== exp.window_fragments) begin
                $error("window_fragments exp %0d got %0d", exp.window_fragments,
                       got.window_fragments);
                errors++;
            end
            if (got.fragment_percent !== exp.fragment_percent) begin
                $error("fragment_percent exp %0d got %0d", exp.fragment_percent,
                       got.fragment_percent);
                errors++;
            end
            if (got.largest_bytes !== exp.largest_bytes) begin
                $error("largest_bytes exp %0d got %0d", exp.largest_bytes,
                       got.largest_bytes);
                errors++;
            end
            if (got.smallest_bytes !== exp.smallest_bytes) begin
                $error("smallest_bytes exp %0d got %0d", exp.smallest_bytes,
                       got.smallest_bytes);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_command;
    logic [30:0] i_now_ms;
    logic [15:0] i_packet_bytes;
    logic        i_fragmented;
    logic        empty;
    logic        pop;
    logic [30:0] o_bytes_per_second;
    logic [10:0] o_window_samples;
    logic [10:0] o_window_fragments;
    logic [6:0]  o_fragment_percent;
    logic [15:0] o_largest_bytes;
    logic [15:0] o_smallest_bytes;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    window_scoreboard sb;
    bit  steady;
    bit  hold_request;
    int  quiet_cycles;
    int  records_sent;
    int  updates_sent;
    int  phases;

    packet_window_statistics dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        push <= 1'b0;
        pop <= 1'b0;
        i_command <= CMD_RECORD;
        i_now_ms <= '0;
        i_packet_bytes <= '0;
        i_fragmented <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_ENABLE;
        i_cfg_data <= '0;
    end

    // result side: random pop, long hold-off on request
    initial begin
        t_result got;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                got.bytes_per_second = o_bytes_per_second;
                got.window_samples = o_window_samples;
                got.window_fragments = o_window_fragments;
                got.fragment_percent = o_fragment_percent;
                got.largest_bytes = o_largest_bytes;
                got.smallest_bytes = o_smallest_bytes;
                sb.check_result(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                pop <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end else begin
                pop <= steady || ($urandom_range(99) >= 23);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 20000) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_beat(logic cmd, logic [30:0] now, logic [15:0] nbytes, logic frag);
        while (!steady && $urandom_range(99) < 23) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_command <= cmd;
        i_now_ms <= now;
        i_packet_bytes <= nbytes;
        i_fragmented <= frag;
        do @(posedge i_clk); while (full);
        sb.note_input(cmd, now, nbytes, frag);
        if (cmd == CMD_UPDATE) updates_sent++; else records_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic setup(logic en, logic [15:0] win, logic [15:0] gap, logic [15:0] mn);
        drain();
        write_cfg(REG_ENABLE, {15'd0, en});
        write_cfg(REG_WINDOW, win);
        write_cfg(REG_INTERVAL, gap);
        write_cfg(REG_EMPTY_MIN, mn);
        phases++;
    endtask

    initial begin
        logic [30:0] now;
        logic [30:0] step;
        sb = new();
        sb.clear();
        steady = 1'b0;
        hold_request = 1'b0;
        records_sent = 0;
        updates_sent = 0;
        phases = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: disabled records, empty window, time zero, ties, future samples
        send_beat(CMD_RECORD, 31'd50, 16'd77, 1'b1);
        send_beat(CMD_UPDATE, 31'd60, 16'd0, 1'b0);
        setup(1'b1, 16'd1000, 16'd100, 16'd9999);
        send_beat(CMD_RECORD, 31'd0, 16'd123, 1'b1);
        send_beat(CMD_RECORD, 31'd5, 16'hffff, 1'b1);
        send_beat(CMD_RECORD, 31'd5, 16'd0, 1'b0);
        send_beat(CMD_UPDATE, 31'd5, 16'hffff, 1'b1);
        send_beat(CMD_RECORD, 31'd900, 16'd1500, 1'b0);
        send_beat(CMD_UPDATE, 31'd500, 16'd0, 1'b0);
        send_beat(CMD_UPDATE, 31'd800, 16'd0, 1'b0);
        setup(1'b1, 16'd1, 16'd0, 16'd0);
        send_beat(CMD_RECORD, 31'h7ffffffe, 16'd40000, 1'b1);
        send_beat(CMD_RECORD, 31'h7fffffff, 16'd65535, 1'b0);
        send_beat(CMD_UPDATE, 31'h7fffffff, 16'd0, 1'b0);
        send_beat(CMD_UPDATE, 31'h7fffffff, 16'd0, 1'b0);
        setup(1'b1, 16'hffff, 16'hffff, 16'hffff);
        send_beat(CMD_RECORD, 31'd70000, 16'd1, 1'b0);
        send_beat(CMD_UPDATE, 31'd70001, 16'd0, 1'b0);
        send_beat(CMD_UPDATE, 31'd135536, 16'd0, 1'b0);
        send_beat(CMD_UPDATE, 31'd135537, 16'd0, 1'b0);

        // random phases
        for (int p = 0; p < 8; p++) begin
            setup($urandom_range(99) < 85,
                  ($urandom_range(3) == 0) ? 16'($urandom_range(65535, 1))
                                           : 16'($urandom_range(600, 1)),
                  ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(150)),
                  16'($urandom));
            steady = (p == 3);
            case ($urandom_range(2))
                0: now = 31'($urandom_range(5000));
                1: now = 31'($urandom);
                default: now = 31'h7fffffff - 31'($urandom_range(4000));
            endcase
            for (int k = 0; k < 50; k++) begin
                step = 31'($urandom_range(40));
                if ($urandom_range(9) == 0) now = (now > 20) ? now - 31'd20 : now;
                else now = (now > 31'h7fffffff - step) ? 31'h7fffffff : now + step;
                if ($urandom_range(99) < 15)
                    send_beat(CMD_UPDATE, now, 16'($urandom), 1'($urandom));
                else
                    send_beat(CMD_RECORD, now, ($urandom_range(7) == 0) ? 16'($urandom)
                              : 16'($urandom_range(1500)), 1'($urandom));
            end
            steady = 1'b0;
        end

        // back pressure: receiver stalls while updates keep coming
        drain();
        hold_request = 1'b1;
        for (int k = 0; k < 30; k++)
            send_beat(CMD_UPDATE, 31'd140000 + 31'(k), 16'd0, 1'b0);

        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d records, %0d updates, %0d results checked over %0d settings",
                 records_sent, updates_sent, sb.checked, phases);
        $display("including disabled, empty, tie, future, extreme-time and stall cases");
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
